FILE: rtl/core/min_heap_sorter_macros.svh
// Assertion helpers used by the heap engine
`ifndef MIN_HEAP_SORTER_MACROS_SVH
`define MIN_HEAP_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mhs_pkg.sv
package mhs_pkg;

    // Default heap capacity
    localparam int MAX_COUNT_DEF = 64;

    // Element width
    localparam int DATA_W = 32;

    // One sorted result handed from the engine to the output stage
    typedef struct packed {
        logic                     overflow;
        logic                     final_res;
        logic signed [DATA_W-1:0] sorted_value;
    } mhs_res_t;

endpackage

FILE: rtl/core/mhs_ram.sv
module mhs_ram #(
    parameter int DEPTH = mhs_pkg::MAX_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    addr,
    input  logic signed [mhs_pkg::DATA_W-1:0] wdata,
    output logic signed [mhs_pkg::DATA_W-1:0] rdata
);
    import mhs_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Single port, read-first, registered read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/mhs_engine.sv
`include "min_heap_sorter_macros.svh"

module mhs_engine #(
    parameter int MAX_COUNT = mhs_pkg::MAX_COUNT_DEF,
    parameter int AW        = $clog2(MAX_COUNT)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input transaction
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [mhs_pkg::DATA_W-1:0] in_value,
    input  logic                              in_last,
    // result toward the output stage
    output logic                              res_valid,
    input  logic                              res_ready,
    output mhs_pkg::mhs_res_t                 res,
    // heap memory port
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_addr,
    output logic signed [mhs_pkg::DATA_W-1:0] mem_wdata,
    input  logic signed [mhs_pkg::DATA_W-1:0] mem_rdata
);
    import mhs_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int PW = CW + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_BUILD = 10'b00_0000_0010,
        S_LOADW = 10'b00_0000_0100,
        S_RDL   = 10'b00_0000_1000,
        S_RDR   = 10'b00_0001_0000,
        S_CMP   = 10'b00_0010_0000,
        S_POP0  = 10'b00_0100_0000,
        S_POP1  = 10'b00_1000_0000,
        S_POP2  = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic                     build_reg, build_next;
    logic [CW-1:0]            par_reg, par_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic signed [DATA_W-1:0] lcv_reg, lcv_next;
    logic signed [DATA_W-1:0] top_reg, top_next;

    logic [PW-1:0]            lc_idx;
    logic [PW-1:0]            rc_idx;
    logic                     lc_ok;
    logic                     rc_ok;
    logic [CW-1:0]            count_inc;
    logic [CW-1:0]            count_dec;
    logic [CW-1:0]            par_dec;
    logic                     has_room;
    logic                     take_left;
    logic                     take_right;
    logic signed [DATA_W-1:0] best_val;
    state_t                   sift_exit;

    // Child indexes of the current slot
    assign lc_idx    = (PW'(pos_reg) << 1) + PW'(1);
    assign rc_idx    = lc_idx + PW'(1);
    assign lc_ok     = lc_idx < PW'(count_reg);
    assign rc_ok     = rc_idx < PW'(count_reg);
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign par_dec   = par_reg - CW'(1);
    assign has_room  = count_reg < CW'(MAX_COUNT);

    // Child selection: left when strictly smaller, then right against the winner
    assign take_left  = v_reg > lcv_reg;
    assign best_val   = take_left ? lcv_reg : v_reg;
    assign take_right = rc_ok && (best_val > mem_rdata);

    // Where a finished sift returns to
    assign sift_exit = build_reg ? S_BUILD : S_POP0;

    assign in_ready            = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_EMIT);
    assign res.sorted_value    = top_reg;
    assign res.final_res       = (count_reg == '0);
    assign res.overflow        = dropped_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        build_next   = build_reg;
        par_next     = par_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        lcv_next     = lcv_reg;
        top_next     = top_reg;
        mem_we       = 1'b0;
        mem_addr     = pos_reg;
        mem_wdata    = v_reg;

        case (state_reg)
            S_IDLE:
            begin
                mem_addr  = count_reg[AW-1:0];
                mem_wdata = in_value;
                if (in_valid)
                begin
                    // store or drop the incoming element
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        build_next = 1'b1;
                        par_next   = (has_room ? count_inc : count_reg) >> 1;
                        state_next = S_BUILD;
                    end
                end
            end

            S_BUILD:
            begin
                // next parent from the bottom, or start popping
                mem_addr = par_dec[AW-1:0];
                if (par_reg == '0)
                begin
                    build_next = 1'b0;
                    state_next = S_POP0;
                end
                else
                begin
                    par_next   = par_dec;
                    pos_next   = par_dec[AW-1:0];
                    state_next = S_LOADW;
                end
            end

            S_LOADW:
            begin
                v_next     = mem_rdata;
                state_next = S_RDL;
            end

            S_RDL:
            begin
                mem_addr = lc_idx[AW-1:0];
                if (lc_ok)
                begin
                    state_next = S_RDR;
                end
                else
                begin
                    // leaf reached: settle the value here
                    mem_addr   = pos_reg;
                    mem_we     = 1'b1;
                    state_next = sift_exit;
                end
            end

            S_RDR:
            begin
                lcv_next   = mem_rdata;
                mem_addr   = rc_idx[AW-1:0];
                state_next = S_CMP;
            end

            S_CMP:
            begin
                mem_we = 1'b1;
                if (take_right)
                begin
                    // move right child up, descend right
                    mem_wdata  = mem_rdata;
                    pos_next   = rc_idx[AW-1:0];
                    state_next = S_RDL;
                end
                else if (take_left)
                begin
                    // move left child up, descend left
                    mem_wdata  = lcv_reg;
                    pos_next   = lc_idx[AW-1:0];
                    state_next = S_RDL;
                end
                else
                begin
                    state_next = sift_exit;
                end
            end

            S_POP0:
            begin
                mem_addr   = '0;
                state_next = S_POP1;
            end

            S_POP1:
            begin
                top_next   = mem_rdata;
                mem_addr   = count_dec[AW-1:0];
                state_next = S_POP2;
            end

            S_POP2:
            begin
                // last entry becomes the new root value
                v_next     = mem_rdata;
                count_next = count_dec;
                pos_next   = '0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    if (count_reg == '0)
                    begin
                        dropped_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RDL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            build_reg   <= 1'b0;
            par_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            build_reg   <= build_next;
            par_reg     <= par_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        v_reg   <= v_next;
        lcv_reg <= lcv_next;
        top_reg <= top_next;
    end

    `MHS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(MAX_COUNT), "element count above capacity")
    `MHS_ASSERT_NEXT(a_final_idle, res_valid && res_ready && res.final_res, (state_reg == S_IDLE) && (count_reg == '0) && !dropped_reg, "run did not close after final result")
    `MHS_ASSERT_NOW(a_wr_addr, mem_we, PW'(mem_addr) < PW'(MAX_COUNT), "heap write beyond capacity")
    `MHS_ASSERT_NOW(a_pop_nonempty, state_reg == S_POP0, count_reg != '0, "pop issued on empty heap")

endmodule

FILE: rtl/core/min_heap_sorter.sv
// Heap sorter. Signed 32-bit values arrive on the slave stream, one per
// transaction, and are stored in a single-port heap memory of MAX_COUNT
// entries; one transaction is taken per cycle while a set is collected.
// The transaction with tlast closes the set: the block stops taking input,
// heapifies the memory bottom-up and then pops the minimum repeatedly, so
// the values leave the master stream in ascending order, duplicates kept,
// with tlast on the final one. Values that do not fit are dropped and
// tuser is high on every result of that set. Every heap step goes through
// the single memory port: a sift-down level is a left child read, a right
// child read and a compare with write-back, and a sift ends at a leaf or
// when the compare keeps the value in place. Each result takes a root
// read, a read of the last entry, the count update and the emit, plus its
// sift. The heapify pass adds a parent read and a load per parent, plus
// the sift of that parent. A finished result waits in an output register
// so the engine can start the next pop meanwhile.
module min_heap_sorter #(
    parameter int MAX_COUNT = mhs_pkg::MAX_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [mhs_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                              s_tlast,   // last
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [mhs_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                              m_tlast,   // final_res
    output logic                              m_tuser    // [0] overflow
);
    import mhs_pkg::*;

    localparam int AW = $clog2(MAX_COUNT);

    logic                     res_valid;
    logic                     res_ready;
    mhs_res_t                 res;
    logic                     mem_we;
    logic [AW-1:0]            mem_addr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata;

    logic                     out_valid_reg, out_valid_next;
    mhs_res_t                 out_res_reg, out_res_next;

    mhs_ram #(
        .DEPTH (MAX_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mhs_engine #(
        .MAX_COUNT (MAX_COUNT),
        .AW        (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Output register: load when empty or draining this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.sorted_value;
    assign m_tlast  = out_res_reg.final_res;
    assign m_tuser  = out_res_reg.overflow;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mhs_pkg::*;

    localparam int CAPACITY   = MAX_COUNT_DEF;
    localparam int NUM_RANDOM = 320;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [DATA_W-1:0] first;
        int                       step;
        int                       reps;
        bit                       closes;
        bit                       pinned;
        mhs_res_t                 pin;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata;   // [31:0] value
    logic                     s_tlast;   // last
    logic                     m_tvalid;
    logic                     m_tready;
    logic signed [DATA_W-1:0] m_tdata;   // [31:0] sorted_value
    logic                     m_tlast;   // final_res
    logic                     m_tuser;   // [0] overflow

    // Predictor copy of the set being collected
    logic signed [DATA_W-1:0] set_vals [CAPACITY];
    int                       set_cnt = 0;
    bit                       set_dropped = 1'b0;
    mhs_res_t                 pending_sorted [$];

    // Fixed expectation that travels with the transaction being offered
    bit                       row_pinned;
    mhs_res_t                 row_pin;

    bit                       calm = 1'b0;
    int                       errors = 0;
    int                       items_sent = 0;
    int                       sets_sent = 0;
    int                       overflow_sets = 0;
    int                       results_seen = 0;

    min_heap_sorter #(
        .MAX_COUNT (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Order the collected set and queue one result per stored value
    function automatic void sort_set();
        logic signed [DATA_W-1:0] ordered [CAPACITY];
        logic signed [DATA_W-1:0] key;
        mhs_res_t                 res;
        int                       j;
        for (int i = 0; i < set_cnt; i++)
            ordered[i] = set_vals[i];
        for (int i = 1; i < set_cnt; i++)
        begin
            key = ordered[i];
            j   = i - 1;
            while (j >= 0 && ordered[j] > key)
            begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        for (int i = 0; i < set_cnt; i++)
        begin
            res.sorted_value = ordered[i];
            res.final_res    = (i == set_cnt - 1);
            res.overflow     = set_dropped;
            pending_sorted.push_back(res);
        end
        set_cnt     = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic stim_row_t mk_row(input logic signed [DATA_W-1:0] first,
                                         input int step,
                                         input int reps,
                                         input bit closes,
                                         input bit pinned);
        stim_row_t r;
        r.first               = first;
        r.step                = step;
        r.reps                = reps;
        r.closes              = closes;
        r.pinned              = pinned;
        // a lone value comes straight back, flagged final, no overflow
        r.pin.sorted_value    = first;
        r.pin.final_res       = 1'b1;
        r.pin.overflow        = 1'b0;
        return r;
    endfunction

    // Mix of full-range, clustered (many duplicates) and extreme values
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 9)
            return $signed($urandom_range(0, 7)) - 4;
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Offer one value after a random gap and hold it until taken
    task automatic send_value(input logic signed [DATA_W-1:0] v, input bit lst,
                              input bit pinned, input mhs_res_t pin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= v;
        s_tlast    <= lst;
        row_pinned <= pinned;
        row_pin    <= pin;
        do @(posedge clk); while (!s_tready);
    endtask

    // Track accepted input transactions in the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            items_sent++;
            if (set_cnt < CAPACITY)
            begin
                set_vals[set_cnt] = s_tdata;
                set_cnt++;
            end
            else
                set_dropped = 1'b1;
            if (s_tlast)
            begin
                sets_sent++;
                if (set_dropped)
                    overflow_sets++;
                if (row_pinned)
                begin
                    pending_sorted.push_back(row_pin);
                    set_cnt     = 0;
                    set_dropped = 1'b0;
                end
                else
                    sort_set();
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        mhs_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sorted.size() == 0)
            begin
                errors++;
                $display("%0t: result %0d with none expected", $time, m_tdata);
            end
            else
            begin
                want = pending_sorted.pop_front();
                results_seen++;
                if (m_tdata !== want.sorted_value)
                begin
                    errors++;
                    $display("%0t: sorted_value expected %0d got %0d",
                             $time, want.sorted_value, m_tdata);
                end
                if (m_tlast !== want.final_res)
                begin
                    errors++;
                    $display("%0t: final_res expected %0b got %0b",
                             $time, want.final_res, m_tlast);
                end
                if (m_tuser !== want.overflow)
                begin
                    errors++;
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, m_tuser);
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge clk);
        gap = $urandom_range(0, 11);
        forever
        begin
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            gap = calm ? 0 : $urandom_range(0, 11);
        end
    end

    // Stimulus: directed table, then random sets
    initial
    begin
        stim_row_t rows [15];
        mhs_res_t  none;
        int        items_queued;
        int        set_len;
        int        r;

        none       = '0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        row_pinned = 1'b0;
        row_pin    = '0;

        // lone extremes come straight back
        rows[0]  = mk_row(32'sh8000_0000, 0, 1, 1, 1);
        rows[1]  = mk_row(32'sh7FFF_FFFF, 0, 1, 1, 1);
        rows[2]  = mk_row(32'sh0000_0000, 0, 1, 1, 1);
        rows[3]  = mk_row(-32'sd1, 0, 1, 1, 1);
        // two values in reverse order
        rows[4]  = mk_row(32'sd5, 0, 1, 0, 0);
        rows[5]  = mk_row(-32'sd5, 0, 1, 1, 0);
        // duplicates around a smaller value
        rows[6]  = mk_row(32'sd7, 0, 2, 0, 0);
        rows[7]  = mk_row(-32'sd3, 0, 1, 0, 0);
        rows[8]  = mk_row(32'sd7, 0, 1, 1, 0);
        // overfill: the last two values, the closing one included, are dropped
        rows[9]  = mk_row(32'sd500, -9, CAPACITY + 2, 1, 0);
        // extremes mixed in one set
        rows[10] = mk_row(32'sh7FFF_FFFF, 0, 1, 0, 0);
        rows[11] = mk_row(32'sh8000_0000, 0, 1, 0, 0);
        rows[12] = mk_row(-32'sd1, 0, 1, 0, 0);
        rows[13] = mk_row(32'sd1, 0, 1, 1, 0);
        // overflow flag must be clear again on the next set
        rows[14] = mk_row(32'sd42, 0, 1, 1, 1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (rows[i])
            for (int k = 0; k < rows[i].reps; k++)
                send_value(rows[i].first + k * rows[i].step,
                           rows[i].closes && (k == rows[i].reps - 1),
                           rows[i].pinned, rows[i].pin);

        // Hold off until every directed result is out
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);

        // Random sets, mostly short, a few at or past capacity
        items_queued = 0;
        while (items_queued < NUM_RANDOM)
        begin
            calm = ($urandom_range(0, 4) == 0);
            r    = $urandom_range(0, 99);
            if (r < 82)
                set_len = $urandom_range(1, 6);
            else if (r < 94)
                set_len = $urandom_range(7, 24);
            else if (r < 97)
                set_len = CAPACITY;
            else
                set_len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            for (int k = 0; k < set_len; k++)
                send_value(pick_value(), k == set_len - 1, 1'b0, none);
            items_queued += set_len;
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results, then allow for stray ones
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d values in %0d sets (%0d overfilled), checked %0d sorted results.",
                 items_sent, sets_sent, overflow_sets, results_seen);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: min_heap_sorter.f
+incdir+rtl/core
rtl/core/mhs_pkg.sv
rtl/core/mhs_ram.sv
rtl/core/mhs_engine.sv
rtl/core/min_heap_sorter.sv
tb/sv/testbench.sv
